// ----- sv/stfd_pkg.sv -----
package stfd_pkg;

   localparam int NUM_SLOTS           = 32;
   localparam int CONTACTS_PER_PACKET = 6;
   localparam int PACKET_LENGTH       = 67;
   localparam int HDR_LEN             = 6;
   localparam int TOUCH_BODY          = 61;
   localparam int MAX_RESULTS         = 64;
   localparam int SLOT_W              = 5;
   localparam int REC_BYTES           = 10;
   localparam int REC_BASE            = 5;
   localparam int COUNT_POS           = 65;

   localparam logic [1:0] EV_END  = 2'd0;
   localparam logic [1:0] EV_DOWN = 2'd1;
   localparam logic [1:0] EV_UP   = 2'd2;
   localparam logic [1:0] EV_MOVE = 2'd3;

   localparam logic [7:0] ST_TAP  = 8'h02;
   localparam logic [7:0] ST_DRAG = 8'h03;

   typedef enum logic [4:0] {
      PH_HEADER   = 5'b00001,
      PH_HUNT0    = 5'b00010,
      PH_HUNT1    = 5'b00100,
      PH_HUNTREST = 5'b01000,
      PH_BODY     = 5'b10000
   } phase_type;

   typedef enum logic [9:0] {
      S_IDLE   = 10'b0000000001,
      S_SETUP  = 10'b0000000010,
      S_LOAD   = 10'b0000000100,
      S_SHIFT  = 10'b0000001000,
      S_STORE  = 10'b0000010000,
      S_EVCHK  = 10'b0000100000,
      S_EVRD   = 10'b0001000000,
      S_EV     = 10'b0010000000,
      S_REL    = 10'b0100000000,
      S_END    = 10'b1000000000
   } state_type;

   function automatic logic [6:0] classify(input logic [7:0] d0, input logic [7:0] d1,
                                           input logic [7:0] d2, input logic [7:0] d3,
                                           input logic [7:0] d4, input logic [7:0] d5);
      logic [6:0] len;
      len = 7'd0;
      if (d0 == 8'h1f && d1 == 8'hf7) begin
         if (d2 == 8'h43 && d3 == 8'h00 && d4 == 8'h02) begin
            len = 7'(TOUCH_BODY);
         end else if (d2 == 8'hfc) begin
            if (d3 == 8'hfe && d4 == 8'h81 && d5 == 8'h02) begin
               len = 7'd4;
            end else if (d3 == 8'hb4) begin
               if ((d4 == 8'h81 || d4 == 8'h82) && d5 == 8'h02) begin
                  len = 7'd4;
               end else if (d4 == 8'h83 && d5 == 8'h0a) begin
                  len = 7'd8;
               end
            end
         end
      end
      return len;
   endfunction

endpackage

// ----- sv/serial_touch_frame_decoder.sv -----
// Decodes the byte stream of a serial touch panel. Each accepted item is one
// received byte, and req_ready is high while no touch packet is being
// reported. A byte that does not complete a valid touch packet is taken in the
// idle state. The last byte of a touch packet with a good checksum starts a
// report sequence on a single sequencer: each new contact record is gathered
// from the packet memory one byte at a time through a load and a shift state,
// each stored contact of a complete frame is evaluated through a read and an
// evaluate state, the release sweep, once the lifted count reaches the frame
// total, visits all 32 slots one per cycle while it can emit, and a final state
// emits the frame-end item. Waits on rsp_ready lengthen this.
module serial_touch_frame_decoder
   import stfd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_event_kind,
   output logic [4:0]  rsp_slot,
   output logic [15:0] rsp_pos_x,
   output logic [15:0] rsp_pos_y,
   output logic [15:0] rsp_contact_width,
   output logic [15:0] rsp_contact_height,
   output logic        rsp_touch_active,
   output logic        rsp_last_of_frame
);

   logic [7:0]  pkt_mem [PACKET_LENGTH];
   logic [79:0] contact_mem [NUM_SLOTS];

   phase_type   phase_ff, phase_in;
   state_type   state_ff, state_in;
   logic [6:0]  pos_ff, pos_in;
   logic [6:0]  exp_ff, exp_in;
   logic [7:0]  sum_ff, sum_in;
   logic [7:0]  hdr_ff [HDR_LEN];
   logic [7:0]  cnt_ff;
   logic [31:0] pressed_ff, pressed_in;
   logic [5:0]  total_ff, total_in;
   logic [5:0]  rc_ff, rc_in;
   logic [5:0]  uc_ff, uc_in;
   logic [2:0]  k_ff, k_in;
   logic [2:0]  ri_ff, ri_in;
   logic [3:0]  j_ff, j_in;
   logic [6:0]  addr_ff, addr_in;
   logic [79:0] rec_ff, rec_in;
   logic [5:0]  e_ff, e_in;
   logic [4:0]  s_ff, s_in;
   logic [6:0]  n_ff, n_in;
   logic        active_ff, active_in;
   logic [7:0]  pkt_rd_ff;
   logic [79:0] crd_ff;

   logic        wr_en;
   logic [6:0]  wr_addr;
   logic        cwr_en;
   logic        accept;
   logic        can_emit;
   logic        emit;
   logic [1:0]  emit_kind;
   logic [4:0]  emit_slot;
   logic [63:0] emit_geom;

   logic        rsp_valid_ff;
   logic [1:0]  rsp_kind_ff;
   logic [4:0]  rsp_slot_ff;
   logic [63:0] rsp_geom_ff;
   logic        rsp_active_ff;
   logic        rsp_last_ff;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign can_emit  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      logic [6:0] p;
      logic [6:0] pn;
      logic [6:0] len;
      logic [5:0] tot;
      logic [5:0] rcn;
      logic [5:0] diff;
      logic [7:0] id;
      logic [7:0] st;
      phase_in   = phase_ff;
      state_in   = state_ff;
      pos_in     = pos_ff;
      exp_in     = exp_ff;
      sum_in     = sum_ff;
      pressed_in = pressed_ff;
      total_in   = total_ff;
      rc_in      = rc_ff;
      uc_in      = uc_ff;
      k_in       = k_ff;
      ri_in      = ri_ff;
      j_in       = j_ff;
      addr_in    = addr_ff;
      rec_in     = rec_ff;
      e_in       = e_ff;
      s_in       = s_ff;
      n_in       = n_ff;
      active_in  = active_ff;
      wr_en      = 1'b0;
      wr_addr    = pos_ff;
      cwr_en     = 1'b0;
      emit       = 1'b0;
      emit_kind  = EV_END;
      emit_slot  = '0;
      emit_geom  = '0;
      p          = '0;
      pn         = '0;
      len        = '0;
      tot        = '0;
      rcn        = '0;
      diff       = '0;
      id         = crd_ff[15:8];
      st         = crd_ff[7:0];
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (phase_ff)
                  PH_HUNT0: begin
                     wr_en   = 1'b1;
                     wr_addr = 7'd0;
                     sum_in  = req_rx_byte;
                     if (req_rx_byte == 8'h1f) phase_in = PH_HUNT1;
                  end
                  PH_HUNT1: begin
                     wr_en   = 1'b1;
                     wr_addr = 7'd1;
                     sum_in  = sum_ff + req_rx_byte;
                     if (req_rx_byte == 8'hf7) begin
                        phase_in = PH_HUNTREST;
                        pos_in   = 7'd2;
                     end else begin
                        phase_in = PH_HUNT0;
                     end
                  end
                  PH_HUNTREST: begin
                     p       = (pos_ff < 7'd2 || pos_ff > 7'd5) ? 7'd2 : pos_ff;
                     wr_en   = 1'b1;
                     wr_addr = p;
                     sum_in  = sum_ff + req_rx_byte;
                     pn      = p + 7'd1;
                     pos_in  = pn;
                     if (pn == 7'(HDR_LEN)) begin
                        if (hdr_ff[2] == 8'h43 && hdr_ff[3] == 8'h00 && hdr_ff[4] == 8'h02)
                        begin
                           exp_in   = 7'(TOUCH_BODY);
                           phase_in = PH_BODY;
                        end else begin
                           phase_in = PH_HUNT0;
                           pos_in   = 7'd0;
                        end
                     end
                  end
                  PH_BODY: begin
                     if (pos_ff < 7'(HDR_LEN) || pos_ff >= 7'(PACKET_LENGTH)) begin
                        phase_in = PH_HEADER;
                        pos_in   = 7'd0;
                     end else begin
                        wr_en   = 1'b1;
                        wr_addr = pos_ff;
                        if (pos_ff < 7'(PACKET_LENGTH - 1)) sum_in = sum_ff + req_rx_byte;
                        pn      = pos_ff + 7'd1;
                        pos_in  = pn;
                        if (pn >= 7'(HDR_LEN) + exp_ff) begin
                           pos_in   = 7'd0;
                           phase_in = PH_HEADER;
                           if (exp_ff == 7'(TOUCH_BODY)) begin
                              if (sum_ff != req_rx_byte) begin
                                 phase_in = PH_HUNT0;
                              end else begin
                                 state_in = S_SETUP;
                              end
                           end
                        end
                     end
                  end
                  default: begin
                     p       = (pos_ff > 7'd5) ? 7'd0 : pos_ff;
                     wr_en   = 1'b1;
                     wr_addr = p;
                     sum_in  = (p == 7'd0) ? req_rx_byte : sum_ff + req_rx_byte;
                     pn      = p + 7'd1;
                     pos_in  = pn;
                     if (pn == 7'(HDR_LEN)) begin
                        len = classify(hdr_ff[0], hdr_ff[1], hdr_ff[2], hdr_ff[3],
                                       hdr_ff[4], req_rx_byte);
                        if (len == 7'd0) begin
                           phase_in = PH_HUNT0;
                           pos_in   = 7'd0;
                        end else begin
                           exp_in   = len;
                           phase_in = PH_BODY;
                        end
                     end
                  end
               endcase
            end
         end
         S_SETUP: begin
            tot = total_ff;
            rcn = rc_ff;
            if (cnt_ff != 8'd0) begin
               tot   = (cnt_ff > 8'(NUM_SLOTS)) ? 6'(NUM_SLOTS) : cnt_ff[5:0];
               rcn   = 6'd0;
               uc_in = 6'd0;
            end
            total_in = tot;
            rc_in    = rcn;
            diff     = tot - rcn;
            k_in     = (diff > 6'(CONTACTS_PER_PACKET)) ? 3'(CONTACTS_PER_PACKET) : diff[2:0];
            ri_in    = 3'd0;
            j_in     = 4'd0;
            addr_in  = 7'(REC_BASE);
            n_in     = 7'd0;
            if (diff != 6'd0 && rcn < 6'(NUM_SLOTS)) begin
               state_in = S_LOAD;
            end else begin
               state_in = S_EVCHK;
            end
         end
         S_LOAD: begin
            state_in = S_SHIFT;
         end
         S_SHIFT: begin
            rec_in  = {pkt_rd_ff, rec_ff[79:8]};
            addr_in = addr_ff + 7'd1;
            j_in    = j_ff + 4'd1;
            if (j_ff == 4'(REC_BYTES - 1)) begin
               state_in = S_STORE;
            end else begin
               state_in = S_LOAD;
            end
         end
         S_STORE: begin
            cwr_en = 1'b1;
            rc_in  = rc_ff + 6'd1;
            ri_in  = ri_ff + 3'd1;
            j_in   = 4'd0;
            if (ri_ff + 3'd1 < k_ff && rc_ff + 6'd1 < 6'(NUM_SLOTS)) begin
               state_in = S_LOAD;
            end else begin
               state_in = S_EVCHK;
            end
         end
         S_EVCHK: begin
            e_in = 6'd0;
            s_in = 5'd0;
            if (rc_ff >= total_ff && total_ff != 6'd0) begin
               state_in = S_EVRD;
            end else begin
               active_in = (uc_ff < total_ff);
               state_in  = (uc_ff >= total_ff) ? S_REL : S_END;
            end
         end
         S_EVRD: begin
            state_in = S_EV;
         end
         S_EV: begin
            if (id < 8'(NUM_SLOTS) && (st == ST_TAP || st == ST_DRAG)) begin
               if (can_emit) begin
                  emit      = 1'b1;
                  emit_slot = id[SLOT_W-1:0];
                  n_in      = n_ff + 7'd1;
                  if (st == ST_TAP && pressed_ff[id[SLOT_W-1:0]]) begin
                     emit_kind                  = EV_UP;
                     pressed_in[id[SLOT_W-1:0]] = 1'b0;
                     if (uc_ff < 6'd63) uc_in = uc_ff + 6'd1;
                  end else begin
                     emit_kind                  = (st == ST_TAP) ? EV_DOWN : EV_MOVE;
                     emit_geom                  = crd_ff[79:16];
                     pressed_in[id[SLOT_W-1:0]] = 1'b1;
                  end
               end
            end
            if (!emit && (id < 8'(NUM_SLOTS) && (st == ST_TAP || st == ST_DRAG))) begin
               state_in = S_EV;
            end else begin
               e_in = e_ff + 6'd1;
               if (e_ff + 6'd1 < total_ff) begin
                  state_in = S_EVRD;
               end else begin
                  active_in = (uc_in < total_ff);
                  state_in  = (uc_in >= total_ff) ? S_REL : S_END;
               end
            end
         end
         S_REL: begin
            if (pressed_ff[s_ff] && n_ff < 7'(MAX_RESULTS - 1) && !can_emit) begin
               state_in = S_REL;
            end else begin
               if (pressed_ff[s_ff]) begin
                  pressed_in[s_ff] = 1'b0;
                  if (n_ff < 7'(MAX_RESULTS - 1)) begin
                     emit      = 1'b1;
                     emit_kind = EV_UP;
                     emit_slot = s_ff;
                     n_in      = n_ff + 7'd1;
                  end
               end
               s_in     = s_ff + 5'd1;
               state_in = (s_ff == 5'(NUM_SLOTS - 1)) ? S_END : S_REL;
            end
         end
         S_END: begin
            if (can_emit) begin
               emit      = 1'b1;
               emit_kind = EV_END;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) pkt_mem[wr_addr] <= req_rx_byte;
      pkt_rd_ff <= pkt_mem[addr_ff];
      if (cwr_en) contact_mem[rc_ff[SLOT_W-1:0]] <= rec_ff;
      crd_ff <= contact_mem[e_ff[SLOT_W-1:0]];
      if (wr_en && wr_addr < 7'(HDR_LEN)) hdr_ff[wr_addr[2:0]] <= req_rx_byte;
      if (wr_en && wr_addr == 7'(COUNT_POS)) cnt_ff <= req_rx_byte;
      k_ff      <= k_in;
      ri_ff     <= ri_in;
      j_ff      <= j_in;
      addr_ff   <= addr_in;
      rec_ff    <= rec_in;
      e_ff      <= e_in;
      s_ff      <= s_in;
      n_ff      <= n_in;
      active_ff <= active_in;
      if (emit) begin
         rsp_kind_ff   <= emit_kind;
         rsp_slot_ff   <= emit_slot;
         rsp_geom_ff   <= emit_geom;
         rsp_active_ff <= (emit_kind == EV_END) ? active_ff : 1'b0;
         rsp_last_ff   <= (emit_kind == EV_END);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HEADER;
         state_ff     <= S_IDLE;
         pos_ff       <= '0;
         exp_ff       <= '0;
         sum_ff       <= '0;
         pressed_ff   <= '0;
         total_ff     <= '0;
         rc_ff        <= '0;
         uc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         state_ff   <= state_in;
         pos_ff     <= pos_in;
         exp_ff     <= exp_in;
         sum_ff     <= sum_in;
         pressed_ff <= pressed_in;
         total_ff   <= total_in;
         rc_ff      <= rc_in;
         uc_ff      <= uc_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_event_kind     = rsp_kind_ff;
   assign rsp_slot           = rsp_slot_ff;
   assign rsp_pos_x          = rsp_geom_ff[15:0];
   assign rsp_pos_y          = rsp_geom_ff[31:16];
   assign rsp_contact_width  = rsp_geom_ff[47:32];
   assign rsp_contact_height = rsp_geom_ff[63:48];
   assign rsp_touch_active   = rsp_active_ff;
   assign rsp_last_of_frame  = rsp_last_ff;

   a_last_is_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_of_frame |-> rsp_event_kind == EV_END && rsp_slot == 5'd0)
      else $error("frame-end item carries a contact");

   a_up_no_geom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_kind == EV_UP |-> rsp_pos_x == 16'd0 && rsp_pos_y == 16'd0)
      else $error("up item carries coordinates");

   a_store_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_STORE |-> rc_ff < 6'(NUM_SLOTS))
      else $error("contact store written past its depth");

   a_eval_in_frame: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EV |-> e_ff < total_ff && total_ff <= rc_ff)
      else $error("evaluated contact outside the frame");

endmodule

// ----- tb/sv/serial_touch_frame_decoder_test.sv -----
module serial_touch_frame_decoder_test;
   import stfd_pkg::*;

   localparam int CYCLE_LIMIT = 500000;
   localparam int HOLD_CYCLES = 600;
   localparam int DRAIN_CYCLES = 400;

   localparam int P_HEADER   = 0;
   localparam int P_HUNT0    = 1;
   localparam int P_HUNT1    = 2;
   localparam int P_HUNTREST = 3;
   localparam int P_BODY     = 4;

   localparam logic [7:0] ST_OTHER = 8'h05;

   typedef struct packed {
      logic [1:0]  kind;
      logic [4:0]  slot;
      logic [15:0] x;
      logic [15:0] y;
      logic [15:0] w;
      logic [15:0] h;
      logic        active;
      logic        last;
   } report_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_event_kind;
   logic [4:0]  rsp_slot;
   logic [15:0] rsp_pos_x;
   logic [15:0] rsp_pos_y;
   logic [15:0] rsp_contact_width;
   logic [15:0] rsp_contact_height;
   logic        rsp_touch_active;
   logic        rsp_last_of_frame;

   serial_touch_frame_decoder uut (.*);

   // Decoder state tracked by the testbench.
   int         parse_phase = P_HEADER;
   int         parse_pos = 0;
   int         body_len = 0;
   logic [7:0] frame_bytes [PACKET_LENGTH];
   logic [7:0] byte_sum = 8'h00;
   logic [7:0] rec_id [NUM_SLOTS];
   logic [7:0] rec_status [NUM_SLOTS];
   logic [15:0] rec_x [NUM_SLOTS];
   logic [15:0] rec_y [NUM_SLOTS];
   logic [15:0] rec_w [NUM_SLOTS];
   logic [15:0] rec_h [NUM_SLOTS];
   logic [31:0] pressed = 32'h0;
   int         frame_total = 0;
   int         gathered = 0;
   int         released = 0;

   report_t    pending_reports [$];
   int         failures = 0;
   int         reports_seen = 0;
   int         bytes_sent = 0;
   int         cycles = 0;
   bit         calm = 1'b0;
   bit         hold_req = 1'b0;
   logic [7:0] pkt [PACKET_LENGTH];

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("serial_touch_frame_decoder: mismatch");
         $finish;
      end
   end

   function automatic void push_report(logic [1:0] kind, logic [4:0] slot, int idx,
                                       logic active, logic last);
      report_t r;
      r = '0;
      r.kind = kind;
      r.slot = slot;
      if (idx >= 0) begin
         r.x = rec_x[idx];
         r.y = rec_y[idx];
         r.w = rec_w[idx];
         r.h = rec_h[idx];
      end
      r.active = active;
      r.last = last;
      pending_reports.push_back(r);
   endfunction

   function automatic int header_body_len();
      if (frame_bytes[0] != 8'h1f || frame_bytes[1] != 8'hf7) return 0;
      if (frame_bytes[2] == 8'h43 && frame_bytes[3] == 8'h00 && frame_bytes[4] == 8'h02)
         return TOUCH_BODY;
      if (frame_bytes[2] != 8'hfc) return 0;
      if (frame_bytes[3] == 8'hfe && frame_bytes[4] == 8'h81 && frame_bytes[5] == 8'h02)
         return 4;
      if (frame_bytes[3] != 8'hb4) return 0;
      if ((frame_bytes[4] == 8'h81 || frame_bytes[4] == 8'h82) && frame_bytes[5] == 8'h02)
         return 4;
      if (frame_bytes[4] == 8'h83 && frame_bytes[5] == 8'h0a) return 8;
      return 0;
   endfunction

   function automatic void report_touch_frame();
      int count;
      int k;
      int base;
      int made;
      logic active;
      count = int'(frame_bytes[COUNT_POS]);
      made = 0;
      if (count > 0) begin
         frame_total = (count > NUM_SLOTS) ? NUM_SLOTS : count;
         gathered = 0;
         released = 0;
      end
      k = frame_total - gathered;
      if (k > CONTACTS_PER_PACKET) k = CONTACTS_PER_PACKET;
      for (int i = 0; i < k && gathered < NUM_SLOTS; i++) begin
         base = REC_BYTES * i + REC_BASE;
         rec_status[gathered] = frame_bytes[base];
         rec_id[gathered] = frame_bytes[base + 1];
         rec_x[gathered] = {frame_bytes[base + 3], frame_bytes[base + 2]};
         rec_y[gathered] = {frame_bytes[base + 5], frame_bytes[base + 4]};
         rec_w[gathered] = {frame_bytes[base + 7], frame_bytes[base + 6]};
         rec_h[gathered] = {frame_bytes[base + 9], frame_bytes[base + 8]};
         gathered++;
      end
      if (gathered >= frame_total) begin
         for (int i = 0; i < frame_total; i++) begin
            if (rec_id[i] < NUM_SLOTS) begin
               if (rec_status[i] == ST_TAP) begin
                  if (!pressed[rec_id[i]]) begin
                     pressed[rec_id[i]] = 1'b1;
                     push_report(EV_DOWN, rec_id[i][4:0], i, 1'b0, 1'b0);
                  end else begin
                     if (released < 63) released++;
                     pressed[rec_id[i]] = 1'b0;
                     push_report(EV_UP, rec_id[i][4:0], -1, 1'b0, 1'b0);
                  end
                  made++;
               end else if (rec_status[i] == ST_DRAG) begin
                  pressed[rec_id[i]] = 1'b1;
                  push_report(EV_MOVE, rec_id[i][4:0], i, 1'b0, 1'b0);
                  made++;
               end
            end
         end
      end
      active = 1'b1;
      if (released >= frame_total) begin
         for (int s = 0; s < NUM_SLOTS; s++) begin
            if (pressed[s]) begin
               pressed[s] = 1'b0;
               if (made < MAX_RESULTS - 1) begin
                  push_report(EV_UP, 5'(s), -1, 1'b0, 1'b0);
                  made++;
               end
            end
         end
         active = 1'b0;
      end
      push_report(EV_END, 5'd0, -1, active, 1'b1);
   endfunction

   function automatic void take_byte(logic [7:0] b);
      int len;
      case (parse_phase)
         P_HUNT0: begin
            frame_bytes[0] = b;
            byte_sum = b;
            if (b == 8'h1f) parse_phase = P_HUNT1;
         end
         P_HUNT1: begin
            frame_bytes[1] = b;
            byte_sum = byte_sum + b;
            if (b == 8'hf7) begin
               parse_phase = P_HUNTREST;
               parse_pos = 2;
            end else begin
               parse_phase = P_HUNT0;
            end
         end
         P_HUNTREST: begin
            if (parse_pos < 2 || parse_pos > 5) parse_pos = 2;
            frame_bytes[parse_pos] = b;
            byte_sum = byte_sum + b;
            parse_pos++;
            if (parse_pos == HDR_LEN) begin
               if (frame_bytes[2] == 8'h43 && frame_bytes[3] == 8'h00 &&
                   frame_bytes[4] == 8'h02) begin
                  body_len = TOUCH_BODY;
                  parse_phase = P_BODY;
               end else begin
                  parse_phase = P_HUNT0;
                  parse_pos = 0;
               end
            end
         end
         P_BODY: begin
            if (parse_pos < HDR_LEN || parse_pos >= PACKET_LENGTH) begin
               parse_phase = P_HEADER;
               parse_pos = 0;
            end else begin
               frame_bytes[parse_pos] = b;
               if (parse_pos < PACKET_LENGTH - 1) byte_sum = byte_sum + b;
               parse_pos++;
               if (parse_pos >= HDR_LEN + body_len) begin
                  parse_pos = 0;
                  parse_phase = P_HEADER;
                  if (body_len == TOUCH_BODY) begin
                     if (byte_sum != frame_bytes[PACKET_LENGTH - 1]) parse_phase = P_HUNT0;
                     else report_touch_frame();
                  end
               end
            end
         end
         default: begin
            if (parse_pos > 5) parse_pos = 0;
            frame_bytes[parse_pos] = b;
            byte_sum = (parse_pos == 0) ? b : byte_sum + b;
            parse_pos++;
            if (parse_pos == HDR_LEN) begin
               len = header_body_len();
               if (len == 0) begin
                  parse_phase = P_HUNT0;
                  parse_pos = 0;
               end else begin
                  body_len = len;
                  parse_phase = P_BODY;
               end
            end
         end
      endcase
   endfunction

   function automatic void check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected %0h, got %0h", name, exp_v, act_v);
         failures++;
      end
   endfunction

   always @(posedge clock) begin
      report_t e;
      if (!reset && rsp_valid && rsp_ready) begin
         reports_seen++;
         if (pending_reports.size() == 0) begin
            $error("unexpected item: kind %0d slot %0d", rsp_event_kind, rsp_slot);
            failures++;
         end else begin
            e = pending_reports.pop_front();
            check_field("event_kind", 16'(e.kind), 16'(rsp_event_kind));
            check_field("slot", 16'(e.slot), 16'(rsp_slot));
            check_field("pos_x", e.x, rsp_pos_x);
            check_field("pos_y", e.y, rsp_pos_y);
            check_field("contact_width", e.w, rsp_contact_width);
            check_field("contact_height", e.h, rsp_contact_height);
            check_field("touch_active", 16'(e.active), 16'(rsp_touch_active));
            check_field("last_of_frame", 16'(e.last), 16'(rsp_last_of_frame));
         end
      end
      if (!reset && req_valid && req_ready) take_byte(req_rx_byte);
   end

   initial begin
      forever begin
         @(negedge clock);
         if (hold_req) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_req = 1'b0;
         end else begin
            rsp_ready <= calm || ($urandom_range(0, 99) >= 13);
         end
      end
   end

   // Entered and left at a falling edge.
   task automatic send_byte(logic [7:0] b);
      if (!calm && $urandom_range(0, 99) < 13) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (!(req_valid && req_ready));
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic put_record(int i, logic [7:0] status, logic [7:0] id);
      int base;
      base = REC_BYTES * i + REC_BASE;
      pkt[base] = status;
      pkt[base + 1] = id;
      for (int j = 2; j < REC_BYTES; j++) pkt[base + j] = 8'($urandom);
   endtask

   task automatic start_packet();
      pkt[0] = 8'h1f;
      pkt[1] = 8'hf7;
      pkt[2] = 8'h43;
      pkt[3] = 8'h00;
      pkt[4] = 8'h02;
      for (int i = 0; i < CONTACTS_PER_PACKET; i++)
         put_record(i, ST_OTHER, 8'($urandom_range(0, 255)));
   endtask

   task automatic send_packet(logic [7:0] count, bit bad_sum);
      logic [7:0] s;
      pkt[COUNT_POS] = count;
      s = 8'h00;
      for (int i = 0; i < PACKET_LENGTH - 1; i++) s = s + pkt[i];
      pkt[PACKET_LENGTH - 1] = bad_sum ? s ^ 8'(1 << $urandom_range(0, 7)) : s;
      for (int i = 0; i < PACKET_LENGTH; i++) send_byte(pkt[i]);
   endtask

   task automatic send_ack(int kind);
      logic [7:0] h [HDR_LEN];
      int tail;
      h = '{8'h1f, 8'hf7, 8'hfc, 8'hb4, 8'h81, 8'h02};
      tail = 4;
      case (kind)
         0: h[3] = 8'hfe;
         1: ;
         2: h[4] = 8'h82;
         default: begin
            h[4] = 8'h83;
            h[5] = 8'h0a;
            tail = 8;
         end
      endcase
      for (int i = 0; i < HDR_LEN; i++) send_byte(h[i]);
      repeat (tail) send_byte(8'($urandom));
   endtask

   task automatic random_frame_packet(bit bad_sum);
      int n;
      start_packet();
      for (int i = 0; i < CONTACTS_PER_PACKET; i++) begin
         n = $urandom_range(0, 9);
         put_record(i, n < 5 ? ST_TAP : (n < 8 ? ST_DRAG : 8'($urandom)),
                    $urandom_range(0, 9) == 0 ? 8'($urandom_range(32, 255))
                                              : 8'($urandom_range(0, 7)));
      end
      n = $urandom_range(0, 9);
      send_packet(n < 6 ? 8'($urandom_range(1, 6)) :
                  (n < 8 ? 8'h00 : 8'($urandom_range(7, 255))), bad_sum);
   endtask

   task automatic test_acks();
      for (int k = 0; k < 4; k++) send_ack(k);
   endtask

   task automatic test_down_move_up();
      start_packet();
      put_record(0, ST_TAP, 8'd0);
      send_packet(8'd1, 1'b0);
      start_packet();
      put_record(0, ST_DRAG, 8'd31);
      put_record(1, ST_OTHER, 8'd1);
      send_packet(8'd2, 1'b0);
      start_packet();
      put_record(0, ST_TAP, 8'd0);
      put_record(1, ST_TAP, 8'd31);
      send_packet(8'd2, 1'b0);
      for (int i = 0; i < PACKET_LENGTH; i++) pkt[i] = 8'hff;
      start_packet();
      put_record(0, ST_DRAG, 8'd5);
      for (int j = 2; j < REC_BYTES; j++) pkt[REC_BASE + j] = 8'hff;
      send_packet(8'd1, 1'b0);
      start_packet();
      put_record(0, ST_DRAG, 8'd5);
      for (int j = 2; j < REC_BYTES; j++) pkt[REC_BASE + j] = 8'h00;
      send_packet(8'h00, 1'b0);
   endtask

   task automatic test_multi_packet_frame();
      start_packet();
      for (int i = 0; i < CONTACTS_PER_PACKET; i++) put_record(i, ST_TAP, 8'(i + 10));
      send_packet(8'd9, 1'b0);
      start_packet();
      put_record(0, ST_DRAG, 8'd20);
      put_record(1, ST_TAP, 8'd32);
      put_record(2, ST_DRAG, 8'd255);
      send_packet(8'h00, 1'b0);
   endtask

   task automatic test_clamp_to_slots();
      for (int p = 0; p < 6; p++) begin
         start_packet();
         for (int i = 0; i < CONTACTS_PER_PACKET; i++)
            put_record(i, ST_TAP, 8'((p * CONTACTS_PER_PACKET + i) % NUM_SLOTS));
         send_packet(p == 0 ? 8'hff : 8'h00, 1'b0);
      end
      start_packet();
      put_record(0, ST_TAP, 8'd3);
      send_packet(8'd1, 1'b0);
   endtask

   task automatic test_hunting();
      start_packet();
      put_record(0, ST_TAP, 8'd4);
      send_packet(8'd1, 1'b1);
      send_byte(8'h1f);
      send_byte(8'h1f);
      send_byte(8'hf7);
      send_byte(8'hfc);
      send_byte(8'hb4);
      send_byte(8'h81);
      send_byte(8'h02);
      send_byte(8'h00);
      start_packet();
      put_record(0, ST_TAP, 8'd4);
      send_packet(8'd1, 1'b0);
      send_byte(8'h55);
      start_packet();
      put_record(0, ST_DRAG, 8'd6);
      send_packet(8'd1, 1'b0);
   endtask

   task automatic test_random_stream();
      int n;
      int start_bytes;
      start_bytes = bytes_sent;
      while (bytes_sent - start_bytes < 130) begin
         calm = ($urandom_range(0, 19) == 0) ? ~calm : calm;
         n = $urandom_range(0, 19);
         if (n < 15) begin
            random_frame_packet(1'b0);
         end else if (n < 17) begin
            send_ack($urandom_range(0, 3));
         end else if (n < 18) begin
            random_frame_packet(1'b1);
         end else begin
            repeat ($urandom_range(1, 12)) send_byte(8'($urandom));
         end
      end
      calm = 1'b0;
   endtask

   task automatic test_output_stall();
      hold_req = 1'b1;
      for (int p = 0; p < 4; p++) random_frame_packet(1'b0);
      wait (!hold_req);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_acks();
      test_down_move_up();
      test_multi_packet_frame();
      test_clamp_to_slots();
      test_hunting();
      test_output_stall();
      test_random_stream();
      req_valid <= 1'b0;
      wait (pending_reports.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("serial_touch_frame_decoder: match");
      end else begin
         $display("serial_touch_frame_decoder: mismatch");
      end
      $finish;
   end

endmodule
